>>> src/footprint_grid_collision_check_assert.svh
// ----------------------------------------------------------------------------
// Footprint grid collision check: assertion macros
// Concurrent assertion wrappers, empty when synthesising.
// ----------------------------------------------------------------------------
`ifndef FOOTPRINT_GRID_COLLISION_CHECK_ASSERT_SVH
`define FOOTPRINT_GRID_COLLISION_CHECK_ASSERT_SVH

`ifndef SYNTHESIS

// Property must hold at every edge outside reset
`define FGCC_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("fgcc assertion failed");

// Condition must never be true outside reset
`define FGCC_NEVER(lbl, clk, rstn, cond) \
  `FGCC_ASSERT(lbl, clk, rstn, !(cond))

`else

`define FGCC_ASSERT(lbl, clk, rstn, prop)
`define FGCC_NEVER(lbl, clk, rstn, cond)

`endif

`endif

>>> src/fgcc_pkg.sv
// ----------------------------------------------------------------------------
// Footprint grid collision check package
// Shared sizes, register indexes, status codes and bundle types.
// ----------------------------------------------------------------------------
package fgcc_pkg;

  // Grid storage
  localparam int GRID_ROWS = 256;
  localparam int GRID_COLS = 256;
  localparam int GRID_MAX  = (GRID_ROWS > GRID_COLS) ? GRID_ROWS : GRID_COLS;
  localparam int ADDR_W    = $clog2(GRID_ROWS * GRID_COLS);

  // Quotient width of a cell index, and signed index width
  localparam int QW = $clog2(GRID_MAX + 1);
  localparam int IW = QW + 1;

  // Datapath width
  localparam int DW = 64;

  // Register indexes
  localparam logic [2:0] REG_ORIGIN_X    = 3'd0;
  localparam logic [2:0] REG_ORIGIN_Y    = 3'd1;
  localparam logic [2:0] REG_CELL_SIZE   = 3'd2;
  localparam logic [2:0] REG_ROWS_IN_USE = 3'd3;
  localparam logic [2:0] REG_COLS_IN_USE = 3'd4;
  localparam logic [2:0] REG_HARD_COST   = 3'd5;
  localparam logic [2:0] REG_HALF_LENGTH = 3'd6;
  localparam logic [2:0] REG_HALF_WIDTH  = 3'd7;

  // Commands
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_CHECK = 1'b1;

  // Result status codes
  localparam logic [2:0] ST_SAFE      = 3'd0;
  localparam logic [2:0] ST_OOB       = 3'd1;
  localparam logic [2:0] ST_NONFINITE = 3'd2;
  localparam logic [2:0] ST_INVALID   = 3'd3;
  localparam logic [2:0] ST_BLOCKED   = 3'd4;

  // Cell value codes
  localparam logic [7:0] VAL_NONFINITE = 8'd255;
  localparam logic [7:0] VAL_MAX_RISK  = 8'd100;

  typedef struct packed {
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic [30:0]        cell_size;
    logic [8:0]         rows_in_use;
    logic [8:0]         cols_in_use;
    logic [6:0]         hard_cost;
    logic [30:0]        half_length;
    logic [30:0]        half_width;
  } cfg_t;

  typedef struct packed {
    logic          start;
    logic [DW-1:0] num;
    logic [DW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic          busy;
    logic          done;
    logic [QW-1:0] quo;
  } div_rsp_t;

endpackage

>>> src/fgcc_if.sv
// ----------------------------------------------------------------------------
// Footprint grid collision check channels
// Valid/ready channels for items, results and register writes.
// ----------------------------------------------------------------------------
interface fgcc_in_if;
  logic               valid;
  logic               ready;
  logic               cmd;
  logic [7:0]         cell_row;
  logic [7:0]         cell_col;
  logic [7:0]         cell_value;
  logic signed [31:0] center_x;
  logic signed [31:0] center_y;
  logic signed [15:0] query_cos;
  logic signed [15:0] query_sin;
  logic signed [31:0] vehicle_x;
  logic signed [31:0] vehicle_y;
  logic signed [15:0] vehicle_cos;
  logic signed [15:0] vehicle_sin;

  modport source (
    output valid, cmd, cell_row, cell_col, cell_value, center_x, center_y,
           query_cos, query_sin, vehicle_x, vehicle_y, vehicle_cos, vehicle_sin,
    input  ready
  );
  modport sink (
    input  valid, cmd, cell_row, cell_col, cell_value, center_x, center_y,
           query_cos, query_sin, vehicle_x, vehicle_y, vehicle_cos, vehicle_sin,
    output ready
  );
endinterface

interface fgcc_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;

  modport source (output valid, status, input ready);
  modport sink (input valid, status, output ready);
endinterface

interface fgcc_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> src/fgcc_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write and one registered read per cycle; contents undefined at reset.
// ----------------------------------------------------------------------------
module fgcc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/fgcc_cfg.sv
// ----------------------------------------------------------------------------
// Footprint grid collision check register file
// Decodes register write beats and holds the configuration.
// ----------------------------------------------------------------------------
module fgcc_cfg (
  input  logic          clk_i,
  input  logic          rst_ni,
  fgcc_cfg_if.sink      cfg_i,
  output fgcc_pkg::cfg_t cfg_o
);
  import fgcc_pkg::*;

  cfg_t cfg_q;

  assign cfg_i.ready = 1'b1;

  // Take one register per write beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.origin_x    <= '0;
      cfg_q.origin_y    <= '0;
      cfg_q.cell_size   <= 31'd6554;
      cfg_q.rows_in_use <= 9'd256;
      cfg_q.cols_in_use <= 9'd256;
      cfg_q.hard_cost   <= 7'd100;
      cfg_q.half_length <= 31'd32768;
      cfg_q.half_width  <= 31'd32768;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_ORIGIN_X:    cfg_q.origin_x    <= $signed(cfg_i.data);
        REG_ORIGIN_Y:    cfg_q.origin_y    <= $signed(cfg_i.data);
        REG_CELL_SIZE:   cfg_q.cell_size   <= cfg_i.data[30:0];
        REG_ROWS_IN_USE: cfg_q.rows_in_use <= cfg_i.data[8:0];
        REG_COLS_IN_USE: cfg_q.cols_in_use <= cfg_i.data[8:0];
        REG_HARD_COST:   cfg_q.hard_cost   <= cfg_i.data[6:0];
        REG_HALF_LENGTH: cfg_q.half_length <= cfg_i.data[30:0];
        REG_HALF_WIDTH:  cfg_q.half_width  <= cfg_i.data[30:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> src/fgcc_div.sv
// ----------------------------------------------------------------------------
// Footprint grid collision check cell index divider
// Restoring divider, one quotient bit per cycle, for small quotients.
// ----------------------------------------------------------------------------
module fgcc_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  fgcc_pkg::div_req_t req_i,
  output fgcc_pkg::div_rsp_t rsp_o
);
  import fgcc_pkg::*;

  localparam int CNT_W = $clog2(QW + 1);

  logic [DW-1:0]    rem_q;
  logic [DW-1:0]    dsr_q;
  logic [QW-1:0]    quo_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q;
  logic             done_q;
  logic             take;

  assign take = (rem_q >= dsr_q);

  // Sequence control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(QW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Shift and subtract
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= req_i.num;
      dsr_q <= req_i.den << (QW - 1);
      quo_q <= '0;
    end else if (busy_q) begin
      if (take) begin
        rem_q <= rem_q - dsr_q;
      end
      quo_q <= {quo_q[QW-2:0], take};
      dsr_q <= dsr_q >> 1;
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;

endmodule

>>> src/footprint_grid_collision_check.sv
// ----------------------------------------------------------------------------
// Footprint grid collision check
// Risk grid store and oriented footprint overlap test on one shared multiplier.
// ----------------------------------------------------------------------------
// Input channel: one beat is either a grid cell write (cmd 0) or a pose check
// (cmd 1). Every input beat yields exactly one status beat on the output
// channel. The register channel is always ready and should only be written
// while no item is in flight.
// A cell write goes straight to its status. A pose check runs 8 setup
// multiplies, a bounds test and four cell index divisions on the bit-serial
// divider; then, per grid row under the bounding box, a row multiply and four
// products, and per cell a cell multiply, four products, a test and, for a cell
// that overlaps, a grid read and judgement. The single multiplier serves every
// multiply; input is not taken while an item is in work.
// Reset clears the control state and the registers to their defaults; grid
// cells are undefined until written, with no clearing pass.
// A stalled output holds its status in the output register; the next item is
// taken while it waits, and its own result waits until the register frees.
// ----------------------------------------------------------------------------
`include "footprint_grid_collision_check_assert.svh"

module footprint_grid_collision_check (
  input  logic       clk_i,
  input  logic       rst_ni,
  fgcc_in_if.sink    in_i,
  fgcc_out_if.source out_o,
  fgcc_cfg_if.sink   cfg_i
);
  import fgcc_pkg::*;

  localparam int MA = 48;
  localparam int MB = 18;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_PRE   = 4'd1;
  localparam logic [3:0] S_BND   = 4'd2;
  localparam logic [3:0] S_DLD   = 4'd3;
  localparam logic [3:0] S_DWT   = 4'd4;
  localparam logic [3:0] S_WCHK  = 4'd5;
  localparam logic [3:0] S_ROWM  = 4'd6;
  localparam logic [3:0] S_ROWP  = 4'd7;
  localparam logic [3:0] S_CELM  = 4'd8;
  localparam logic [3:0] S_CELP  = 4'd9;
  localparam logic [3:0] S_TEST  = 4'd10;
  localparam logic [3:0] S_JUDGE = 4'd11;
  localparam logic [3:0] S_FIN   = 4'd12;

  function automatic logic signed [DW-1:0] mag_w(input logic signed [DW-1:0] v);
    return v[DW-1] ? -v : v;
  endfunction

  cfg_t     cfg;
  div_req_t div_req;
  div_rsp_t div_rsp;

  // Control state
  logic [3:0] state_q, state_d;
  logic [2:0] k_q, k_d;
  logic [1:0] sel_q, sel_d;
  logic [2:0] stat_q, stat_d;
  logic       out_valid_q, out_valid_d;
  logic [2:0] status_q;

  // Captured query
  logic signed [31:0] cx_q, cy_q, vx_q, vy_q;
  logic signed [15:0] qc_q, qs_q, vc_q, vs_q;

  // Derived per query
  logic signed [DW-1:0] ext_x_q, ext_y_q, gx_q, gy_q;
  logic signed [DW-1:0] len_lim_q, wid_lim_q, vproj_q;
  logic signed [IW-1:0] c0_q, c1_q, r0_q, r1_q, r_q, c_q;

  // Per row and per cell
  logic signed [DW-1:0] dy_q, vdy_q, dyqs_q, dyqc_q, vdyvs_q, vdyvc_q;
  logic signed [DW-1:0] dx_q, vdx_q, slen_q, swid_q, lx_q, ly_q;

  // Shared multiplier
  logic signed [MA-1:0]    mul_a;
  logic signed [MB-1:0]    mul_b;
  logic signed [MA+MB-1:0] mul_full;
  logic signed [DW-1:0]    mul_p;

  logic [15:0] ac, as_m, vac, vas;
  logic [30:0] res;
  logic [QW-1:0] rows, cols;
  logic signed [IW-1:0] rows_m1, cols_m1, quo_s;
  logic signed [DW-1:0] cx31, cy31, ox31, oy31, step, half31, hl31, hw31;
  logic signed [DW-1:0] ox2, oy2;
  logic oob, judge, fail, adv, last_c, last_r, accept;
  logic [2:0] fail_code;
  logic [7:0] rd_val;
  logic ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;

  fgcc_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  fgcc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  fgcc_ram #(
    .WIDTH (8),
    .DEPTH (GRID_ROWS * GRID_COLS)
  ) u_grid (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (in_i.cell_value),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (rd_val)
  );

  // Configuration derived values
  always_comb begin
    res  = (cfg.cell_size == '0) ? 31'd1 : cfg.cell_size;
    rows = (32'(cfg.rows_in_use) > GRID_ROWS) ? QW'(GRID_ROWS) : QW'(cfg.rows_in_use);
    cols = (32'(cfg.cols_in_use) > GRID_COLS) ? QW'(GRID_COLS) : QW'(cfg.cols_in_use);
    rows_m1 = $signed({1'b0, rows}) - IW'(1);
    cols_m1 = $signed({1'b0, cols}) - IW'(1);
    ac   = qc_q[15] ? 16'(-qc_q) : 16'(qc_q);
    as_m = qs_q[15] ? 16'(-qs_q) : 16'(qs_q);
    vac  = vc_q[15] ? 16'(-vc_q) : 16'(vc_q);
    vas  = vs_q[15] ? 16'(-vs_q) : 16'(vs_q);
    cx31 = DW'(cx_q) <<< 15;
    cy31 = DW'(cy_q) <<< 15;
    ox31 = DW'(cfg.origin_x) <<< 15;
    oy31 = DW'(cfg.origin_y) <<< 15;
    ox2  = DW'(cfg.origin_x) <<< 1;
    oy2  = DW'(cfg.origin_y) <<< 1;
    step   = DW'(res) << 15;
    half31 = DW'(res) << 14;
    hl31   = DW'(cfg.half_length) << 15;
    hw31   = DW'(cfg.half_width) << 15;
  end

  // Select multiplier operands for the current step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_PRE: begin
        case (k_q)
          3'd0: begin mul_a = MA'(cfg.half_length); mul_b = MB'(ac);   end
          3'd1: begin mul_a = MA'(cfg.half_width);  mul_b = MB'(as_m); end
          3'd2: begin mul_a = MA'(cfg.half_length); mul_b = MB'(as_m); end
          3'd3: begin mul_a = MA'(cfg.half_width);  mul_b = MB'(ac);   end
          3'd4: begin mul_a = MA'(res); mul_b = MB'(cols); end
          3'd5: begin mul_a = MA'(res); mul_b = MB'(rows); end
          3'd6: begin mul_a = MA'(res); mul_b = MB'(17'(ac) + 17'(as_m)); end
          default: begin mul_a = MA'(res); mul_b = MB'(17'(vac) + 17'(vas)); end
        endcase
      end
      S_ROWM: begin mul_a = MA'(res); mul_b = MB'({r_q, 1'b1}); end
      S_CELM: begin mul_a = MA'(res); mul_b = MB'({c_q, 1'b1}); end
      S_ROWP: begin
        case (k_q[1:0])
          2'd0:    begin mul_a = MA'(dy_q);  mul_b = MB'(qs_q); end
          2'd1:    begin mul_a = MA'(dy_q);  mul_b = MB'(qc_q); end
          2'd2:    begin mul_a = MA'(vdy_q); mul_b = MB'(vs_q); end
          default: begin mul_a = MA'(vdy_q); mul_b = MB'(vc_q); end
        endcase
      end
      S_CELP: begin
        case (k_q[1:0])
          2'd0:    begin mul_a = MA'(dx_q);  mul_b = MB'(qc_q); end
          2'd1:    begin mul_a = MA'(dx_q);  mul_b = MB'(qs_q); end
          2'd2:    begin mul_a = MA'(vdx_q); mul_b = MB'(vc_q); end
          default: begin mul_a = MA'(vdx_q); mul_b = MB'(vs_q); end
        endcase
      end
      default: ;
    endcase
  end

  assign mul_full = mul_a * mul_b;
  assign mul_p    = DW'(mul_full);

  // Bounds and per-cell tests
  always_comb begin
    oob = (cx31 - ext_x_q < ox31) || (cy31 - ext_y_q < oy31) ||
          (cx31 + ext_x_q > gx_q) || (cy31 + ext_y_q > gy_q);
    judge = !((mag_w(dx_q) <<< 14) >= half31 + ext_x_q) &&
            !((mag_w(dy_q) <<< 14) >= half31 + ext_y_q) &&
            !(mag_w(slen_q) >= len_lim_q) &&
            !(mag_w(swid_q) >= wid_lim_q) &&
            !((mag_w(lx_q) + vproj_q <= hl31) && (mag_w(ly_q) + vproj_q <= hw31));
    fail      = 1'b1;
    fail_code = ST_SAFE;
    if (rd_val == VAL_NONFINITE) begin
      fail_code = ST_NONFINITE;
    end else if (rd_val > VAL_MAX_RISK) begin
      fail_code = ST_INVALID;
    end else if (rd_val >= {1'b0, cfg.hard_cost}) begin
      fail_code = ST_BLOCKED;
    end else begin
      fail = 1'b0;
    end
    last_c = (c_q == c1_q);
    last_r = (r_q == r1_q);
    adv    = ((state_q == S_TEST) && !judge) || ((state_q == S_JUDGE) && !fail);
    quo_s  = $signed({1'b0, div_rsp.quo});
  end

  // Grid port
  assign accept    = in_i.valid && in_i.ready;
  assign ram_we    = accept && (in_i.cmd == CMD_WRITE) &&
                     (32'(in_i.cell_row) < GRID_ROWS) && (32'(in_i.cell_col) < GRID_COLS);
  assign ram_waddr = ADDR_W'(in_i.cell_row) * ADDR_W'(GRID_COLS) + ADDR_W'(in_i.cell_col);
  assign ram_raddr = ADDR_W'(r_q[QW-1:0]) * ADDR_W'(GRID_COLS) + ADDR_W'(c_q[QW-1:0]);

  // Sequencer
  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    sel_d   = sel_q;
    stat_d  = stat_q;
    ram_re  = 1'b0;
    div_req.start = 1'b0;
    case (sel_q)
      2'd0:    div_req.num = DW'(cx31 - ext_x_q - ox31);
      2'd1:    div_req.num = DW'(cx31 + ext_x_q - ox31);
      2'd2:    div_req.num = DW'(cy31 - ext_y_q - oy31);
      default: div_req.num = DW'(cy31 + ext_y_q - oy31);
    endcase
    div_req.den = DW'(step);
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (in_i.cmd == CMD_CHECK) begin
            state_d = S_PRE;
            k_d     = '0;
          end else begin
            stat_d  = ST_SAFE;
            state_d = S_FIN;
          end
        end
      end
      S_PRE: begin
        k_d = k_q + 1'b1;
        if (k_q == 3'd7) state_d = S_BND;
      end
      S_BND: begin
        if (oob) begin
          stat_d  = ST_OOB;
          state_d = S_FIN;
        end else begin
          sel_d   = '0;
          state_d = S_DLD;
        end
      end
      S_DLD: begin
        div_req.start = 1'b1;
        state_d       = S_DWT;
      end
      S_DWT: begin
        if (div_rsp.done) begin
          if (sel_q == 2'd3) begin
            state_d = S_WCHK;
          end else begin
            sel_d   = sel_q + 1'b1;
            state_d = S_DLD;
          end
        end
      end
      S_WCHK: begin
        if ((r0_q > r1_q) || (c0_q > c1_q)) begin
          stat_d  = ST_SAFE;
          state_d = S_FIN;
        end else begin
          state_d = S_ROWM;
        end
      end
      S_ROWM: begin
        k_d     = '0;
        state_d = S_ROWP;
      end
      S_ROWP: begin
        k_d = k_q + 1'b1;
        if (k_q == 3'd3) state_d = S_CELM;
      end
      S_CELM: begin
        k_d     = '0;
        state_d = S_CELP;
      end
      S_CELP: begin
        k_d = k_q + 1'b1;
        if (k_q == 3'd3) state_d = S_TEST;
      end
      S_TEST: begin
        if (judge) begin
          ram_re  = 1'b1;
          state_d = S_JUDGE;
        end
      end
      S_JUDGE: begin
        if (fail) begin
          stat_d  = fail_code;
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_q || out_o.ready) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
    // Step to the next cell in row order
    if (adv) begin
      if (!last_c) begin
        state_d = S_CELM;
      end else if (!last_r) begin
        state_d = S_ROWM;
      end else begin
        stat_d  = ST_SAFE;
        state_d = S_FIN;
      end
    end
  end

  // Output register handover
  assign out_valid_d = (out_valid_q && !out_o.ready) ||
                       ((state_q == S_FIN) && (!out_valid_q || out_o.ready));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      k_q         <= '0;
      sel_q       <= '0;
      stat_q      <= ST_SAFE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      k_q         <= k_d;
      sel_q       <= sel_d;
      stat_q      <= stat_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if ((state_q == S_FIN) && (!out_valid_q || out_o.ready)) begin
      status_q <= stat_q;
    end
    if ((state_q == S_IDLE) && accept) begin
      cx_q <= in_i.center_x;
      cy_q <= in_i.center_y;
      qc_q <= in_i.query_cos;
      qs_q <= in_i.query_sin;
      vx_q <= in_i.vehicle_x;
      vy_q <= in_i.vehicle_y;
      vc_q <= in_i.vehicle_cos;
      vs_q <= in_i.vehicle_sin;
    end
    case (state_q)
      S_PRE: begin
        case (k_q)
          3'd0: ext_x_q <= mul_p <<< 1;
          3'd1: ext_x_q <= ext_x_q + (mul_p <<< 1);
          3'd2: ext_y_q <= mul_p <<< 1;
          3'd3: ext_y_q <= ext_y_q + (mul_p <<< 1);
          3'd4: gx_q    <= (DW'(cfg.origin_x) + mul_p) <<< 15;
          3'd5: gy_q    <= (DW'(cfg.origin_y) + mul_p) <<< 15;
          3'd6: begin
            len_lim_q <= hl31 + mul_p;
            wid_lim_q <= hw31 + mul_p;
          end
          default: vproj_q <= mul_p;
        endcase
      end
      S_DWT: begin
        if (div_rsp.done) begin
          case (sel_q)
            2'd0:    c0_q <= quo_s;
            2'd1:    c1_q <= (quo_s > cols_m1) ? cols_m1 : quo_s;
            2'd2:    r0_q <= quo_s;
            default: r1_q <= (quo_s > rows_m1) ? rows_m1 : quo_s;
          endcase
        end
      end
      S_WCHK: r_q <= r0_q;
      S_ROWM: begin
        dy_q  <= oy2 + mul_p - (DW'(cy_q) <<< 1);
        vdy_q <= oy2 + mul_p - (DW'(vy_q) <<< 1);
      end
      S_ROWP: begin
        case (k_q[1:0])
          2'd0:    dyqs_q  <= mul_p;
          2'd1:    dyqc_q  <= mul_p;
          2'd2:    vdyvs_q <= mul_p;
          default: begin
            vdyvc_q <= mul_p;
            c_q     <= c0_q;
          end
        endcase
      end
      S_CELM: begin
        dx_q  <= ox2 + mul_p - (DW'(cx_q) <<< 1);
        vdx_q <= ox2 + mul_p - (DW'(vx_q) <<< 1);
      end
      S_CELP: begin
        case (k_q[1:0])
          2'd0:    slen_q <= dyqs_q + mul_p;
          2'd1:    swid_q <= dyqc_q - mul_p;
          2'd2:    lx_q   <= vdyvs_q + mul_p;
          default: ly_q   <= vdyvc_q - mul_p;
        endcase
      end
      default: ;
    endcase
    if (adv) begin
      if (!last_c) begin
        c_q <= c_q + IW'(1);
      end else if (!last_r) begin
        r_q <= r_q + IW'(1);
      end
    end
  end

  assign in_i.ready   = (state_q == S_IDLE);
  assign out_o.valid  = out_valid_q;
  assign out_o.status = status_q;

  `FGCC_ASSERT(a_busy_after_accept, clk_i, rst_ni, accept |=> !in_i.ready)
  `FGCC_ASSERT(a_result_from_fin, clk_i, rst_ni, $rose(out_o.valid) |-> ($past(state_q) == S_FIN))
  `FGCC_NEVER(a_grid_rw_clash, clk_i, rst_ni, ram_re && ram_we)
  `FGCC_NEVER(a_div_restart, clk_i, rst_ni, div_req.start && div_rsp.busy)

endmodule

>>> sim/footprint_grid_collision_check_chk.sv
// ----------------------------------------------------------------------------
// Footprint grid collision check: scoreboard
// Watches the item, status and register channels, keeps a shadow of the
// registers and the risk grid, predicts the status of every item and compares
// it with the status beats in order.
// ----------------------------------------------------------------------------
module footprint_grid_collision_check_chk (
  input  logic        clk_i,
  input  logic        rst_ni,
  fgcc_in_if          in_mon,
  fgcc_out_if         out_mon,
  fgcc_cfg_if         cfg_mon,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);
  import fgcc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // Shadow registers and grid
  longint     org_x, org_y, cell_sz, rows_use, cols_use, hard_lim, half_len, half_wid;
  logic [7:0] risk_grid [0:GRID_ROWS*GRID_COLS-1];
  logic [2:0] status_q [$];

  function automatic longint mag(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  // Walk the cells under the footprint and judge the first failing one
  function automatic logic [2:0] footprint_status(
    input logic signed [31:0] cxi, cyi,
    input logic signed [15:0] qci, qsi,
    input logic signed [31:0] vxi, vyi,
    input logic signed [15:0] vci, vsi
  );
    longint cx, cy, qc, qs, vx, vy, vc, vs, abs_c, abs_s, res, rows, cols;
    longint ext_x, ext_y, cx31, cy31, ox31, oy31, gx31, gy31, step;
    longint c0, c1, r0, r1, half31, len_lim, wid_lim, vproj, hl31, hw31;
    longint py, dy, vdy, px, dx, vdx, lx, ly, r, c;
    logic [7:0] v;
    cx = cxi; cy = cyi; qc = qci; qs = qsi;
    vx = vxi; vy = vyi; vc = vci; vs = vsi;
    abs_c = mag(qc);
    abs_s = mag(qs);
    res  = (cell_sz == 0) ? 1 : cell_sz;
    rows = (rows_use > GRID_ROWS) ? GRID_ROWS : rows_use;
    cols = (cols_use > GRID_COLS) ? GRID_COLS : cols_use;
    ext_x = 2 * (half_len * abs_c + half_wid * abs_s);
    ext_y = 2 * (half_len * abs_s + half_wid * abs_c);
    cx31 = cx * 32768;
    cy31 = cy * 32768;
    ox31 = org_x * 32768;
    oy31 = org_y * 32768;
    gx31 = (org_x + cols * res) * 32768;
    gy31 = (org_y + rows * res) * 32768;
    if (cx31 - ext_x < ox31 || cy31 - ext_y < oy31 || cx31 + ext_x > gx31 ||
        cy31 + ext_y > gy31)
      return ST_OOB;
    step = res * 32768;
    c0 = (cx31 - ext_x - ox31) / step;
    c1 = (cx31 + ext_x - ox31) / step;
    r0 = (cy31 - ext_y - oy31) / step;
    r1 = (cy31 + ext_y - oy31) / step;
    if (c1 > cols - 1) c1 = cols - 1;
    if (r1 > rows - 1) r1 = rows - 1;
    half31  = res * 16384;
    len_lim = half_len * 32768 + res * (abs_c + abs_s);
    wid_lim = half_wid * 32768 + res * (abs_c + abs_s);
    vproj   = res * (mag(vc) + mag(vs));
    hl31    = half_len * 32768;
    hw31    = half_wid * 32768;
    for (r = r0; r <= r1; r++) begin
      py  = 2 * org_y + (2 * r + 1) * res;
      dy  = py - 2 * cy;
      vdy = py - 2 * vy;
      for (c = c0; c <= c1; c++) begin
        px = 2 * org_x + (2 * c + 1) * res;
        dx = px - 2 * cx;
        // Drop cells separated on any of the four axes
        if (mag(dx) * 16384 >= half31 + ext_x) continue;
        if (mag(dy) * 16384 >= half31 + ext_y) continue;
        if (mag(dx * qc + dy * qs) >= len_lim) continue;
        if (mag(dy * qc - dx * qs) >= wid_lim) continue;
        // Skip cells wholly inside the initial vehicle footprint
        vdx = px - 2 * vx;
        lx  = vdx * vc + vdy * vs;
        ly  = vdy * vc - vdx * vs;
        if (mag(lx) + vproj <= hl31 && mag(ly) + vproj <= hw31) continue;
        v = risk_grid[r * GRID_COLS + c];
        if (v == VAL_NONFINITE) return ST_NONFINITE;
        if (v > VAL_MAX_RISK) return ST_INVALID;
        if (longint'(v) >= hard_lim) return ST_BLOCKED;
      end
    end
    return ST_SAFE;
  endfunction

  // Track registers, predict on item beats, compare on status beats
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      org_x    <= 0;
      org_y    <= 0;
      cell_sz  <= 6554;
      rows_use <= 256;
      cols_use <= 256;
      hard_lim <= 100;
      half_len <= 32768;
      half_wid <= 32768;
      status_q.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (status_q.size() == 0) begin
          $display("%0t: status beat %0d with none expected", $time, out_mon.status);
          fail_count_o <= fail_count_o + 1;
        end else if (out_mon.status !== status_q[0]) begin
          $display("%0t: status mismatch: expected %0d, actual %0d", $time, status_q[0],
                   out_mon.status);
          fail_count_o <= fail_count_o + 1;
          void'(status_q.pop_front());
        end else begin
          void'(status_q.pop_front());
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.cmd == CMD_WRITE) begin
          risk_grid[{in_mon.cell_row, in_mon.cell_col}] = in_mon.cell_value;
          status_q.insert(status_q.size(), ST_SAFE);
        end else begin
          status_q.insert(status_q.size(),
                          footprint_status(in_mon.center_x, in_mon.center_y,
                                           in_mon.query_cos, in_mon.query_sin,
                                           in_mon.vehicle_x, in_mon.vehicle_y,
                                           in_mon.vehicle_cos, in_mon.vehicle_sin));
        end
      end
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          REG_ORIGIN_X:    org_x    <= longint'($signed(cfg_mon.data));
          REG_ORIGIN_Y:    org_y    <= longint'($signed(cfg_mon.data));
          REG_CELL_SIZE:   cell_sz  <= longint'(cfg_mon.data[30:0]);
          REG_ROWS_IN_USE: rows_use <= longint'(cfg_mon.data[8:0]);
          REG_COLS_IN_USE: cols_use <= longint'(cfg_mon.data[8:0]);
          REG_HARD_COST:   hard_lim <= longint'(cfg_mon.data[6:0]);
          REG_HALF_LENGTH: half_len <= longint'(cfg_mon.data[30:0]);
          REG_HALF_WIDTH:  half_wid <= longint'(cfg_mon.data[30:0]);
          default: ;
        endcase
      end
      pending_o <= status_q.size();
    end
  end

endmodule

>>> sim/footprint_grid_collision_check_tb.sv
// ----------------------------------------------------------------------------
// Footprint grid collision check testbench
// Fills the corner of the risk grid that checks can reach, then runs directed
// and random cell writes and pose checks over several register settings with
// random idling on both channels; the scoreboard predicts and compares every
// status beat.
// ----------------------------------------------------------------------------
module footprint_grid_collision_check_tb;
  import fgcc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 10_000_000;
  localparam int unsigned IDLE_PCT    = 34;
  localparam int unsigned STALL_LEN   = 400;
  // Rows and columns of the filled corner; checks keep coverage inside it
  localparam int          FILL_N      = 16;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  int unsigned fail_count, pending;
  bit          idle_on = 1'b0;
  bit          stall_go = 1'b0;

  // Shadow of the register values written, for stimulus shaping
  longint sh_ox, sh_oy, sh_cs, sh_rows, sh_cols, sh_hl, sh_hw;

  fgcc_in_if  in_if ();
  fgcc_out_if out_if ();
  fgcc_cfg_if cfg_if ();

  footprint_grid_collision_check i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  footprint_grid_collision_check_chk i_chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mon       (in_if),
    .out_mon      (out_if),
    .cfg_mon      (cfg_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always #4 clk_i = ~clk_i;

  // Stop a hung run
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("footprint_grid_collision_check_tb NOT OK");
    $finish;
  end

  // Status receiver: random idling plus one long hold-off on request
  initial begin
    int unsigned stall_cnt;
    bit          last_go;
    stall_cnt = 0;
    last_go = 1'b0;
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall_go != last_go) begin
        last_go = stall_go;
        stall_cnt = STALL_LEN;
      end
      if (stall_cnt > 0) begin
        stall_cnt--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= !(idle_on && $urandom_range(99) < IDLE_PCT);
      end
    end
  end

  // Offer one item and hold it until its beat
  task automatic send_item(input logic cmd, input logic [7:0] row, col, val,
                           input logic [31:0] cx, cy, input logic [15:0] qc, qs,
                           input logic [31:0] vx, vy, input logic [15:0] vc, vs);
    if (idle_on && $urandom_range(99) < IDLE_PCT) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.cmd         <= cmd;
    in_if.cell_row    <= row;
    in_if.cell_col    <= col;
    in_if.cell_value  <= val;
    in_if.center_x    <= cx;
    in_if.center_y    <= cy;
    in_if.query_cos   <= qc;
    in_if.query_sin   <= qs;
    in_if.vehicle_x   <= vx;
    in_if.vehicle_y   <= vy;
    in_if.vehicle_cos <= vc;
    in_if.vehicle_sin <= vs;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
  endtask

  task automatic write_cell(input logic [7:0] row, col, val);
    send_item(CMD_WRITE, row, col, val, $urandom, $urandom, 16'($urandom), 16'($urandom),
              $urandom, $urandom, 16'($urandom), 16'($urandom));
  endtask

  task automatic check_pose(input logic [31:0] cx, cy, input logic [15:0] qc, qs,
                            input logic [31:0] vx, vy, input logic [15:0] vc, vs);
    send_item(CMD_CHECK, 8'($urandom), 8'($urandom), 8'($urandom), cx, cy, qc, qs,
              vx, vy, vc, vs);
  endtask

  // Drop valid and wait for every outstanding status
  task automatic drain();
    in_if.valid <= 1'b0;
    repeat (2) @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
  endtask

  task automatic set_regs(input longint ox, oy, cs, rows, cols, hard, hl, hw);
    write_reg(REG_ORIGIN_X, ox[31:0]);
    write_reg(REG_ORIGIN_Y, oy[31:0]);
    write_reg(REG_CELL_SIZE, cs[31:0]);
    write_reg(REG_ROWS_IN_USE, rows[31:0]);
    write_reg(REG_COLS_IN_USE, cols[31:0]);
    write_reg(REG_HARD_COST, hard[31:0]);
    write_reg(REG_HALF_LENGTH, hl[31:0]);
    write_reg(REG_HALF_WIDTH, hw[31:0]);
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
    sh_ox = longint'($signed(ox[31:0]));
    sh_oy = longint'($signed(oy[31:0]));
    sh_cs = (cs[30:0] == 0) ? 1 : longint'(cs[30:0]);
    sh_rows = (rows[8:0] > GRID_ROWS) ? GRID_ROWS : longint'(rows[8:0]);
    sh_cols = (cols[8:0] > GRID_COLS) ? GRID_COLS : longint'(cols[8:0]);
    sh_hl = longint'(hl[30:0]);
    sh_hw = longint'(hw[30:0]);
  endtask

  // Mostly low risk, with some high, invalid and non-finite cells
  function automatic logic [7:0] rand_risk();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 80) return 8'($urandom_range(60));
    if (p < 90) return 8'($urandom_range(61, 100));
    if (p < 95) return 8'($urandom_range(101, 254));
    return VAL_NONFINITE;
  endfunction

  // World coordinate of a cell centre on one axis
  function automatic logic [31:0] cell_mid(input longint org, input longint idx);
    longint p;
    p = org + ((2 * idx + 1) * sh_cs) / 2;
    return p[31:0];
  endfunction

  // Random position inside the coverage on one axis
  function automatic logic [31:0] rand_pos(input longint org, input longint n);
    longint span, off, p;
    span = n * sh_cs;
    off = (span == 0) ? 0 : longint'({1'b0, $urandom, $urandom} % span);
    p = org + off;
    return p[31:0];
  endfunction

  // Random unit heading in Q1.14
  task automatic rand_heading(output logic [15:0] c, s);
    int ci, si;
    ci = int'($urandom_range(32768)) - 16384;
    si = int'($sqrt(real'(16384 * 16384 - ci * ci)));
    if ($urandom_range(1)) si = -si;
    c = ci[15:0];
    s = si[15:0];
  endtask

  // One random item: cell writes, well-formed poses and noise
  task automatic rand_item();
    logic [31:0] cx, cy, vx, vy;
    logic [15:0] qc, qs, vc, vs;
    int unsigned p;
    p = $urandom_range(99);
    if (p < 40) begin
      write_cell(8'($urandom_range(FILL_N - 1)), 8'($urandom_range(FILL_N - 1)),
                 rand_risk());
    end else begin
      rand_heading(qc, qs);
      rand_heading(vc, vs);
      cx = rand_pos(sh_ox, sh_cols);
      cy = rand_pos(sh_oy, sh_rows);
      if (p < 60) begin
        // start pose at the query pose, so covered cells are skipped
        vx = cx; vy = cy; vc = qc; vs = qs;
      end else begin
        vx = rand_pos(sh_ox, sh_cols);
        vy = rand_pos(sh_oy, sh_rows);
      end
      if (p >= 85 && p < 93) begin
        qc = 16'($urandom); qs = 16'($urandom); vc = 16'($urandom); vs = 16'($urandom);
      end else if (p >= 93) begin
        cx = $urandom; cy = $urandom; vx = $urandom; vy = $urandom;
      end
      check_pose(cx, cy, qc, qs, vx, vy, vc, vs);
    end
  endtask

  task automatic rand_phase(input int unsigned n);
    repeat (n) rand_item();
  endtask

  initial begin
    logic [31:0] ax, ay, bx, by;
    in_if.valid = 1'b0;
    in_if.cmd = CMD_WRITE;
    in_if.cell_row = '0;
    in_if.cell_col = '0;
    in_if.cell_value = '0;
    in_if.center_x = '0;
    in_if.center_y = '0;
    in_if.query_cos = '0;
    in_if.query_sin = '0;
    in_if.vehicle_x = '0;
    in_if.vehicle_y = '0;
    in_if.vehicle_cos = '0;
    in_if.vehicle_sin = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = REG_ORIGIN_X;
    cfg_if.data = '0;
    sh_ox = 0; sh_oy = 0; sh_cs = 6554; sh_rows = 256; sh_cols = 256;
    sh_hl = 32768; sh_hw = 32768;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Fill the corner back to back; every check keeps its cells inside it
    for (int r = 0; r < FILL_N; r++)
      for (int c = 0; c < FILL_N; c++)
        write_cell(r[7:0], c[7:0], rand_risk());
    idle_on = 1'b1;

    // Reset settings: a few checks whose footprint stays in the filled corner
    check_pose(cell_mid(sh_ox, 8), cell_mid(sh_oy, 8), 16'sd16384, 16'sd0,
               cell_mid(sh_ox, 8), cell_mid(sh_oy, 8), 16'sd16384, 16'sd0);
    check_pose(cell_mid(sh_ox, 7), cell_mid(sh_oy, 8), 16'sd11585, 16'sd11585,
               32'd0, 32'd0, 16'sd0, -16'sd16384);
    check_pose(32'h8000_0000, 32'h7fff_ffff, 16'sd16384, 16'sd0,
               32'h7fff_ffff, 32'h8000_0000, 16'sd0, 16'sd16384);
    drain();

    // Directed: cell value classes under a small footprint
    set_regs(0, 0, 6554, 16, 16, 100, 6554, 3277);
    write_cell(8'd2, 8'd2, VAL_NONFINITE);
    write_cell(8'd5, 8'd5, 8'd150);
    write_cell(8'd8, 8'd8, VAL_MAX_RISK);
    write_cell(8'd11, 8'd11, 8'd101);
    write_cell(8'd14, 8'd14, 8'd254);
    write_cell(8'd0, 8'd0, 8'd0);
    write_cell(8'd255, 8'd255, 8'd0);
    bx = cell_mid(sh_ox, 200);
    by = cell_mid(sh_oy, 200);
    for (int k = 2; k <= 14; k += 3)
      check_pose(cell_mid(sh_ox, k), cell_mid(sh_oy, k), 16'sd16384, 16'sd0,
                 bx, by, 16'sd16384, 16'sd0);
    ax = cell_mid(sh_ox, 2);
    ay = cell_mid(sh_oy, 2);
    // same cell, start pose on top of it: the cell is skipped
    check_pose(ax, ay, 16'sd16384, 16'sd0, ax, ay, 16'sd16384, 16'sd0);
    check_pose(ax, ay, -16'sd16384, 16'sd0, bx, by, 16'sd0, -16'sd16384);
    check_pose(ax, ay, 16'sd0, 16'sd16384, 32'h8000_0000, 32'h7fff_ffff,
               16'h8000, 16'h7fff);
    // heading outside the unit range
    check_pose(cell_mid(sh_ox, 7), cell_mid(sh_oy, 7), 16'h8000, 16'h7fff,
               bx, by, 16'h7fff, 16'h8000);
    check_pose(cell_mid(sh_ox, 255), cell_mid(sh_oy, 255), 16'sd16384, 16'sd0,
               bx, by, 16'sd16384, 16'sd0);
    check_pose(32'h7fff_ffff, 32'h7fff_ffff, 16'sd16384, 16'sd0, bx, by, 16'sd0,
               16'sd0);
    drain();

    // Random phases over register settings; drains double as sender pauses
    rand_phase(40);
    stall_go = ~stall_go;
    rand_phase(10);
    drain();
    set_regs(-2147483648, -2147483648, 2147483647, 16, 16, 0, 2147483647,
             2147483647);
    rand_phase(40);
    drain();
    set_regs(2147483647, 2147483647, 1, 1, 1, 127, 0, 0);
    rand_phase(30);
    drain();
    set_regs(1000, -1000, 0, 0, 511, 50, 1, 2);
    rand_phase(30);
    drain();
    set_regs(-70000, 120000, 65536, 16, 12, 100, 65536, 32768);
    rand_phase(25);
    stall_go = ~stall_go;
    rand_phase(25);
    drain();
    set_regs(-100000, 50000, 20000, 12, 16, 30, 30000, 10000);
    rand_phase(40);
    drain();
    set_regs(0, 0, 6554, 16, 16, 100, 6554, 3277);
    rand_phase(40);
    drain();

    repeat (100) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("footprint_grid_collision_check_tb OK");
    end else begin
      $display("footprint_grid_collision_check_tb NOT OK");
    end
    $finish;
  end

endmodule
